>>> rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/swrr_pkg.sv
// Package of types, codes and constants for the reorder receive window.
`timescale 1ns / 1ps
`default_nettype none

package swrr_pkg;

    localparam int SWRR_DEPTH        = 64;
    localparam int SWRR_PAYLOAD_BITS = 32;
    localparam int WIN_W             = 7;
    localparam int CREDIT_W          = 7;
    localparam int CNT_W             = 7;
    localparam int RESULT_CAP        = 64;
    localparam int CREDIT_MAX        = 127;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd16;

    localparam logic [1:0] OP_PACKET = 2'd0;
    localparam logic [1:0] OP_DRAIN  = 2'd1;
    localparam logic [1:0] OP_ACK    = 2'd2;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] seq_num;
        logic [31:0] payload;
        logic        end_flag;
    } in_item_t;

    typedef struct packed {
        logic                kind;
        logic [31:0]         out_payload;
        logic                out_end;
        logic [31:0]         ack_number;
        logic [CREDIT_W-1:0] window_adv;
        logic                last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PKT_WB,
        ST_DRN_CHK,
        ST_DRN_FLUSH,
        ST_ACK
    } state_t;

endpackage

`default_nettype wire

>>> rtl/sliding_window_reorder_receiver_top.sv
// Top level of the selective-repeat receive window with reorder buffer.
//
// Input channel s_valid/s_ready/s_data carries packet, drain and ack items.
// Result channel m_valid/m_ready/m_data carries delivered entries and acks;
// the final result of an item has last set. cfg_wr_en/cfg_wr_data write the
// receive window length at any edge.
// After reset a clearing pass walks the slot memory, one slot per cycle,
// through all DEPTH slots; s_ready stays low until it is done.
// A packet in the window is a slot read, then a write-back of slot memory.
// An ack is an accept, then a load of the output register once it is free.
// A drain is an accept, one slot read per entry, the read that finds the
// gap, then the flush of the held entry.
// A walk that stops at an eof entry or at 64 entries skips the gap read; an
// empty drain ends at the gap read with no result. Each result holds back
// one entry until the next slot is known.
// The output register frees s_ready for the next item while a result waits.
// When m_ready is low the drain walk pauses; nothing is dropped.
// Once an entry with the eof flag is delivered every later item is taken and
// ignored.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sliding_window_reorder_receiver_top
    import swrr_pkg::*;
#(
    parameter int DEPTH        = SWRR_DEPTH,
    parameter int PAYLOAD_BITS = SWRR_PAYLOAD_BITS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_item_t         s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_item_t             m_data,
    input  wire logic             cfg_wr_en,
    input  wire logic [WIN_W-1:0] cfg_wr_data
);

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int SUM_W  = SLOT_W + 2;
    localparam int WORD_W = PAYLOAD_BITS + 2;
    localparam logic [32:0] WRAP_SPAN = 33'h1_0000_0000;
    localparam int WRAP_REM = int'(WRAP_SPAN % DEPTH);

    state_t state_reg, state_next;

    logic [WIN_W-1:0]        win_reg;
    logic [31:0]             ne_reg;
    logic [31:0]             prev_ack_reg;
    logic [CREDIT_W-1:0]     credit_reg;
    logic                    finished_reg;
    logic [SLOT_W-1:0]       next_slot_reg;
    logic [SLOT_W-1:0]       clr_cnt_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    pend_valid_reg;
    logic [PAYLOAD_BITS-1:0] pend_pay_reg;
    logic                    pend_end_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic                    end_reg;
    logic                    out_valid_reg;
    out_item_t               out_data_reg;

    logic                    ram_wr_en;
    logic [SLOT_W-1:0]       ram_wr_addr;
    logic [WORD_W-1:0]       ram_wr_data;
    logic                    ram_rd_en;
    logic [SLOT_W-1:0]       ram_rd_addr;
    logic [WORD_W-1:0]       ram_rd_data;

    logic                    rd_hit;
    logic                    rd_end;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic                    can_push;
    logic                    push;
    out_item_t               push_data;
    logic                    accept;
    logic                    take;
    logic                    walk_stop;

    logic [31:0]             offset;
    logic [31:0]             eff_win;
    logic                    in_win;
    logic                    seq_wrap;
    logic [SUM_W-1:0]        slot_sum;
    logic [SUM_W-1:0]        slot_red;
    logic [SLOT_W-1:0]       pkt_slot;
    logic [SLOT_W-1:0]       slot_adv;
    logic [63:0]             in_pay_wide;
    logic [63:0]             pend_pay_wide;
    logic [31:0]             ack_diff;
    logic [32:0]             ack_sum;
    logic [CREDIT_W-1:0]     ack_credit;

    swrr_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DEPTH)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_hit   = ram_rd_data[WORD_W-1];
    assign rd_end   = ram_rd_data[PAYLOAD_BITS];
    assign rd_pay   = ram_rd_data[PAYLOAD_BITS-1:0];
    assign can_push = !out_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign take     = rd_hit && (!pend_valid_reg || can_push);
    assign walk_stop = rd_end || (cnt_reg == CNT_W'(RESULT_CAP - 1));

    assign in_pay_wide   = 64'(s_data.payload);
    assign pend_pay_wide = 64'(pend_pay_reg);

    // window check and slot of the arriving sequence number
    assign offset   = s_data.seq_num - ne_reg;
    assign eff_win  = (32'(win_reg) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(win_reg);
    assign in_win   = offset < eff_win;
    assign seq_wrap = s_data.seq_num < ne_reg;

    always_comb begin
        slot_sum = SUM_W'(next_slot_reg) + SUM_W'(offset[SLOT_W-1:0])
                 + (seq_wrap ? SUM_W'(DEPTH - WRAP_REM) : '0);
        if (slot_sum >= SUM_W'(2 * DEPTH)) begin
            slot_red = slot_sum - SUM_W'(2 * DEPTH);
        end else if (slot_sum >= SUM_W'(DEPTH)) begin
            slot_red = slot_sum - SUM_W'(DEPTH);
        end else begin
            slot_red = slot_sum;
        end
        pkt_slot = slot_red[SLOT_W-1:0];
    end

    always_comb begin
        if (ne_reg == '1) begin
            slot_adv = '0;
        end else if (next_slot_reg == SLOT_W'(DEPTH - 1)) begin
            slot_adv = '0;
        end else begin
            slot_adv = next_slot_reg + 1'b1;
        end
    end

    assign ack_diff   = ne_reg - prev_ack_reg;
    assign ack_sum    = 33'(ack_diff) + 33'(credit_reg);
    assign ack_credit = (ack_sum > 33'(CREDIT_MAX)) ? CREDIT_W'(CREDIT_MAX)
                                                    : ack_sum[CREDIT_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == SLOT_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && !finished_reg) begin
                    case (s_data.operation)
                        OP_PACKET: state_next = in_win ? ST_PKT_WB : ST_IDLE;
                        OP_DRAIN:  state_next = ST_DRN_CHK;
                        OP_ACK:    state_next = ST_ACK;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PKT_WB: begin
                state_next = ST_IDLE;
            end
            ST_DRN_CHK: begin
                if (rd_hit) begin
                    if (take && walk_stop) begin
                        state_next = ST_DRN_FLUSH;
                    end
                end else begin
                    state_next = pend_valid_reg ? ST_DRN_FLUSH : ST_IDLE;
                end
            end
            ST_DRN_FLUSH: begin
                if (can_push) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ACK: begin
                if (can_push) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and memory control
    always_comb begin
        s_ready     = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = clr_cnt_reg;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = next_slot_reg;
        push        = 1'b0;
        push_data   = '0;
        case (state_reg)
            ST_CLEAR: begin
                ram_wr_en = 1'b1;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && !finished_reg) begin
                    if (s_data.operation == OP_PACKET && in_win) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = pkt_slot;
                    end else if (s_data.operation == OP_DRAIN) begin
                        ram_rd_en = 1'b1;
                    end
                end
            end
            ST_PKT_WB: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = slot_reg;
                ram_wr_data = {1'b1, end_reg, pay_reg};
            end
            ST_DRN_CHK: begin
                if (take) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = next_slot_reg;
                    push        = pend_valid_reg;
                    push_data.kind        = KIND_DATA;
                    push_data.out_payload = pend_pay_wide[31:0];
                    push_data.out_end     = pend_end_reg;
                    if (!walk_stop) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = slot_adv;
                    end
                end
            end
            ST_DRN_FLUSH: begin
                push = can_push;
                push_data.kind        = KIND_DATA;
                push_data.out_payload = pend_pay_wide[31:0];
                push_data.out_end     = pend_end_reg;
                push_data.last        = 1'b1;
            end
            ST_ACK: begin
                push = can_push;
                push_data.kind       = KIND_ACK;
                push_data.ack_number = ne_reg;
                push_data.window_adv = ack_credit;
                push_data.last       = 1'b1;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            win_reg        <= WINDOW_RESET;
            ne_reg         <= '0;
            prev_ack_reg   <= '0;
            credit_reg     <= CREDIT_W'(WINDOW_RESET);
            finished_reg   <= 1'b0;
            next_slot_reg  <= '0;
            clr_cnt_reg    <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                win_reg <= cfg_wr_data;
            end
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (accept && s_data.operation == OP_DRAIN) begin
                cnt_reg <= '0;
            end
            if (state_reg == ST_PKT_WB && !rd_hit && credit_reg != '0) begin
                credit_reg <= credit_reg - 1'b1;
            end
            if (state_reg == ST_DRN_CHK && take) begin
                pend_valid_reg <= 1'b1;
                ne_reg         <= ne_reg + 1'b1;
                next_slot_reg  <= slot_adv;
                cnt_reg        <= cnt_reg + 1'b1;
                if (rd_end) begin
                    finished_reg <= 1'b1;
                end
            end
            if (state_reg == ST_DRN_FLUSH && can_push) begin
                pend_valid_reg <= 1'b0;
            end
            if (state_reg == ST_ACK && can_push) begin
                credit_reg   <= ack_credit;
                prev_ack_reg <= ne_reg;
            end
            if (push) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            slot_reg <= pkt_slot;
            pay_reg  <= in_pay_wide[PAYLOAD_BITS-1:0];
            end_reg  <= s_data.end_flag;
        end
        if (state_reg == ST_DRN_CHK && take) begin
            pend_pay_reg <= rd_pay;
            pend_end_reg <= rd_end;
        end
        if (push) begin
            out_data_reg <= push_data;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `ASSERT_NEXT(a_finished_freezes, aclk, aresetn, finished_reg, ne_reg == $past(ne_reg))
    `ASSERT_IMPLY(a_drain_cap, aclk, aresetn, state_reg == ST_DRN_CHK, cnt_reg < CNT_W'(RESULT_CAP))
    `ASSERT_IMPLY(a_idle_no_pend, aclk, aresetn, state_reg == ST_IDLE, !pend_valid_reg)

endmodule

`default_nettype wire

>>> rtl/swrr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module swrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
